// ===== rtl/sorted_timer_queue_defines.svh =====
// Assertion macros used by the timer queue controller.
`ifndef SORTED_TIMER_QUEUE_DEFINES_SVH
`define SORTED_TIMER_QUEUE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define STQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define STQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/stq_pkg.sv =====
// Types and constants of the sorted timer queue.
package stq_pkg;
	localparam int MAX_TIMERS = 64;
	localparam int TIME_BITS = 32;
	localparam int SLOT_BITS = 6;
	localparam int IDX_BITS = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_ADD = 2'd0;
	localparam func_t FUNC_ADJUST = 2'd1;
	localparam func_t FUNC_DELETE = 2'd2;
	localparam func_t FUNC_TICK = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_UNLINK,
		ST_INS_START,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_INS_LINK,
		ST_INS_FIX,
		ST_TICK_RD,
		ST_TICK_CMP,
		ST_TICK_PEEK,
		ST_TICK_OUT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_UNLINK,
		CMD_INS_START,
		CMD_WALK_RD,
		CMD_WALK_NEXT,
		CMD_INS_LINK,
		CMD_INS_FIX,
		CMD_TICK_RD,
		CMD_TICK_EMIT
	} cmd_t;

	typedef struct packed {
		logic op_ok;
		logic is_listed;
		logic empty;
		logic found;
		logic at_tail;
		logic due;
		logic last;
		logic walk_done;
	} status_t;
endpackage

// ===== rtl/stq_if.sv =====
// Valid/ready channel carrying a payload of parameterized type.
interface stq_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/stq_datapath.sv =====
// Link memories, list pointers and walk registers of the timer queue.
module stq_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stq_pkg::cmd_t                 cmd,
	input  logic [stq_pkg::SLOT_BITS-1:0] slot,
	input  logic [31:0]                   expire_time,
	input  logic [31:0]                   now_time,
	output stq_pkg::status_t              status,
	output logic [stq_pkg::SLOT_BITS-1:0] out_slot
);
	localparam int IB = stq_pkg::IDX_BITS;
	localparam int TB = stq_pkg::TIME_BITS;

	logic [TB-1:0] time_mem [stq_pkg::MAX_TIMERS];
	logic [IB-1:0] next_mem [stq_pkg::MAX_TIMERS];
	logic [IB-1:0] prev_mem [stq_pkg::MAX_TIMERS];
	logic [stq_pkg::MAX_TIMERS-1:0] listed_q;
	logic [IB-1:0] head_q, tail_q, cur_q, slot_q, prv_q, nxt_q;
	logic empty_q, found_q, slot_ok_q, last_q;
	logic [TB-1:0] etime_q, ntime_q, cur_time_q;
	logic [IB-1:0] cur_next_q;
	logic [IB:0] steps_q;
	logic [IB-1:0] prev_mem_rd;
	logic [IB-1:0] ins_prev;

	function automatic logic [TB-1:0] fit(input logic [31:0] v);
		logic [63:0] w;
		w = {32'd0, v};
		return w[TB-1:0];
	endfunction

	// Read ports: registered reads at the walk pointer, and at the slot on latch.
	always_ff @(posedge clk) begin
		if (cmd == stq_pkg::CMD_WALK_RD || cmd == stq_pkg::CMD_TICK_RD) begin
			cur_time_q <= time_mem[cur_q];
			cur_next_q <= next_mem[cur_q];
		end
		if (cmd == stq_pkg::CMD_WALK_RD) prev_mem_rd <= prev_mem[cur_q];
		if (cmd == stq_pkg::CMD_LATCH) begin
			prv_q <= prev_mem[IB'(slot)];
			nxt_q <= next_mem[IB'(slot)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
			cur_q <= '0;
			found_q <= 1'b0;
			steps_q <= '0;
			slot_q <= '0;
			slot_ok_q <= 1'b0;
			last_q <= 1'b0;
			etime_q <= '0;
			ntime_q <= '0;
		end else begin
			case (cmd)
				stq_pkg::CMD_LATCH: begin
					slot_q <= IB'(slot);
					slot_ok_q <= ({2'b0, slot} < 8'(stq_pkg::MAX_TIMERS));
					etime_q <= fit(expire_time);
					ntime_q <= fit(now_time);
					cur_q <= head_q;
				end
				stq_pkg::CMD_UNLINK: begin
					// Detach slot_q using links latched at dispatch.
					if (slot_q == head_q && slot_q == tail_q) empty_q <= 1'b1;
					else begin
						if (slot_q == head_q) head_q <= nxt_q;
						if (slot_q == tail_q) tail_q <= prv_q;
					end
					listed_q[slot_q] <= 1'b0;
					cur_q <= (slot_q == head_q) ? nxt_q : head_q;
				end
				stq_pkg::CMD_INS_START: begin
					listed_q[slot_q] <= 1'b1;
					found_q <= 1'b0;
					steps_q <= '0;
					cur_q <= head_q;
					if (empty_q) begin
						head_q <= slot_q;
						tail_q <= slot_q;
						empty_q <= 1'b0;
					end
				end
				stq_pkg::CMD_WALK_NEXT: begin
					steps_q <= steps_q + 1'b1;
					if (cur_time_q > etime_q) found_q <= 1'b1;
					else if (cur_q != tail_q) cur_q <= cur_next_q;
				end
				stq_pkg::CMD_INS_LINK: begin
					if (found_q) begin
						if (cur_q == head_q) head_q <= slot_q;
					end else tail_q <= slot_q;
				end
				stq_pkg::CMD_TICK_EMIT: begin
					slot_q <= cur_q;
					listed_q[cur_q] <= 1'b0;
					last_q <= 1'b0;
					if (cur_q == tail_q) begin
						empty_q <= 1'b1;
						last_q <= 1'b1;
					end else begin
						head_q <= cur_next_q;
						cur_q <= cur_next_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Memory writes: one address per memory each cycle. Inserting ahead of
	// an entry links the new slot first, then patches its neighbors.
	assign ins_prev = found_q ? prev_mem_rd : tail_q;

	always_ff @(posedge clk) begin
		case (cmd)
			stq_pkg::CMD_UNLINK: begin
				if (!(slot_q == head_q && slot_q == tail_q)) begin
					if (slot_q != head_q) next_mem[prv_q] <= nxt_q;
					if (slot_q != tail_q) prev_mem[nxt_q] <= prv_q;
				end
			end
			stq_pkg::CMD_INS_START: time_mem[slot_q] <= etime_q;
			stq_pkg::CMD_INS_LINK: begin
				prev_mem[slot_q] <= ins_prev;
				if (found_q) next_mem[slot_q] <= cur_q;
				else next_mem[tail_q] <= slot_q;
			end
			stq_pkg::CMD_INS_FIX: begin
				// Head moved to slot_q when it went in front of the old head.
				prev_mem[cur_q] <= slot_q;
				if (head_q != slot_q) next_mem[ins_prev] <= slot_q;
			end
			default: ;
		endcase
	end

	assign status.op_ok = slot_ok_q;
	assign status.is_listed = listed_q[slot_q];
	assign status.empty = empty_q;
	assign status.found = found_q;
	assign status.at_tail = (cur_q == tail_q);
	assign status.due = !(cur_time_q > ntime_q);
	assign status.last = last_q || (cur_time_q > ntime_q);
	assign status.walk_done = found_q || (cur_time_q > etime_q) || (cur_q == tail_q)
		|| (steps_q >= (IB+1)'(stq_pkg::MAX_TIMERS - 1));
	assign out_slot = stq_pkg::SLOT_BITS'(slot_q);
endmodule

// ===== rtl/stq_ctrl.sv =====
// Sequencer of the timer queue operations.
`include "sorted_timer_queue_defines.svh"
module stq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stq_pkg::func_t    func,
	output logic              out_valid,
	input  logic              out_ready,
	output stq_pkg::cmd_t     cmd,
	input  stq_pkg::status_t  status
);
	stq_pkg::state_t state_q, state_d;
	stq_pkg::func_t func_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::ST_IDLE;
			func_q <= stq_pkg::FUNC_ADD;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) func_q <= func;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = stq_pkg::CMD_NONE;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			stq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd = stq_pkg::CMD_LATCH;
					state_d = stq_pkg::ST_DISPATCH;
				end
			end
			stq_pkg::ST_DISPATCH: begin
				if (func_q == stq_pkg::FUNC_TICK) begin
					state_d = status.empty ? stq_pkg::ST_IDLE : stq_pkg::ST_TICK_RD;
				end else if (!status.op_ok) state_d = stq_pkg::ST_IDLE;
				else if (func_q == stq_pkg::FUNC_ADD)
					state_d = status.is_listed ? stq_pkg::ST_IDLE : stq_pkg::ST_INS_START;
				else state_d = status.is_listed ? stq_pkg::ST_UNLINK : stq_pkg::ST_IDLE;
			end
			stq_pkg::ST_UNLINK: begin
				cmd = stq_pkg::CMD_UNLINK;
				state_d = (func_q == stq_pkg::FUNC_ADJUST) ? stq_pkg::ST_INS_START
					: stq_pkg::ST_IDLE;
			end
			stq_pkg::ST_INS_START: begin
				cmd = stq_pkg::CMD_INS_START;
				state_d = status.empty ? stq_pkg::ST_IDLE : stq_pkg::ST_WALK_RD;
			end
			stq_pkg::ST_WALK_RD: begin
				cmd = stq_pkg::CMD_WALK_RD;
				state_d = stq_pkg::ST_WALK_CMP;
			end
			stq_pkg::ST_WALK_CMP: begin
				cmd = stq_pkg::CMD_WALK_NEXT;
				state_d = status.walk_done ? stq_pkg::ST_INS_LINK : stq_pkg::ST_WALK_RD;
			end
			stq_pkg::ST_INS_LINK: begin
				cmd = stq_pkg::CMD_INS_LINK;
				state_d = status.found ? stq_pkg::ST_INS_FIX : stq_pkg::ST_IDLE;
			end
			stq_pkg::ST_INS_FIX: begin
				cmd = stq_pkg::CMD_INS_FIX;
				state_d = stq_pkg::ST_IDLE;
			end
			stq_pkg::ST_TICK_RD: begin
				cmd = stq_pkg::CMD_TICK_RD;
				state_d = stq_pkg::ST_TICK_CMP;
			end
			stq_pkg::ST_TICK_CMP: begin
				if (status.due) begin
					cmd = stq_pkg::CMD_TICK_EMIT;
					state_d = status.at_tail ? stq_pkg::ST_TICK_OUT : stq_pkg::ST_TICK_PEEK;
				end else state_d = stq_pkg::ST_IDLE;
			end
			stq_pkg::ST_TICK_PEEK: begin
				cmd = stq_pkg::CMD_TICK_RD;
				state_d = stq_pkg::ST_TICK_OUT;
			end
			stq_pkg::ST_TICK_OUT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = status.last ? stq_pkg::ST_IDLE : stq_pkg::ST_TICK_CMP;
			end
			default: state_d = stq_pkg::ST_IDLE;
		endcase
	end

	`STQ_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == stq_pkg::ST_IDLE, "ready outside idle")
	`STQ_ASSERT_IMP(a_out_tick, clk, arst_n, out_valid, func_q == stq_pkg::FUNC_TICK, "result from non-tick")
	`STQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

// ===== rtl/sorted_timer_queue.sv =====
// Top level of the sorted timer queue.
// Usage: in carries one operation beat {func, slot, expire_time, now_time};
// out carries one beat {expired_slot, last_expired} per expired timer.
// Timers are kept in a linked list in slot-indexed link memories, ordered by
// expiry time; equal times keep arrival order.
// One operation is in flight at a time: in.ready is high only when idle.
// An ignored operation ends at dispatch. Add on an empty queue makes the
// slot head and tail; else it reads and compares each entry before the
// insertion point (at most 63), links the slot, and patches the neighbors
// in a further step when the timer goes ahead of an entry; adjust unlinks
// first; delete only unlinks. A tick on an empty queue ends at dispatch;
// else it emits entries from the head while due; each beat before the tail
// waits for the read of the following entry so that last_expired is known.
// A stalled receiver holds the current result beat; the walk waits.
// Reset empties the queue at once (listed bits and empty flag are flops);
// the time and link memories need no clearing pass.
// last_expired marks the final beat of a tick.
module sorted_timer_queue (
	input  logic clk,
	input  logic arst_n,
	stq_if.sink   in,
	stq_if.source out
);
	stq_pkg::cmd_t cmd;
	stq_pkg::status_t status;
	logic [stq_pkg::SLOT_BITS-1:0] out_slot;

	stq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready), .func(in.data.func),
		.out_valid(out.valid), .out_ready(out.ready),
		.cmd(cmd), .status(status)
	);

	stq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.slot(in.data.slot),
		.expire_time(in.data.expire_time), .now_time(in.data.now_time),
		.status(status), .out_slot(out_slot)
	);

	assign out.data.expired_slot = out_slot;
	assign out.data.last_expired = status.last;
endmodule
